FILE: rtl/fcsb_pkg.sv
package fcsb_pkg;

    localparam int PLANES  = 6;
    localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int OP_W    = 2;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int OFS_W   = DATA_W + 1;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = PROD_W + 4;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SPHERE = 2'd1;
    localparam logic [OP_W-1:0] OP_BOX    = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        t_data nx;
        t_data ny;
        t_data nz;
        t_data d;
    } t_plane;

    typedef struct packed {
        logic mul_en;
        logic acc_init;
        logic acc_add;
    } t_mac_ctl;

endpackage

FILE: rtl/fcsb_plane_store.sv
module fcsb_plane_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [fcsb_pkg::PLANE_W-1:0]  i_waddr,
    input  fcsb_pkg::t_plane              i_wdata,
    input  logic [fcsb_pkg::PLANE_W-1:0]  i_raddr,
    output fcsb_pkg::t_plane              o_rdata
);
    import fcsb_pkg::*;

    t_plane r_planes [PLANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PLANES; k++) begin
                r_planes[k] <= '0;
            end
        end else if (i_we) begin
            r_planes[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_planes[i_raddr];

endmodule

FILE: rtl/fcsb_mac.sv
module fcsb_mac (
    input  logic                           i_clk,
    input  fcsb_pkg::t_mac_ctl             i_ctl,
    input  fcsb_pkg::t_data                i_a,
    input  fcsb_pkg::t_data                i_b,
    input  logic signed [fcsb_pkg::OFS_W-1:0] i_offset,
    output logic                           o_positive
);
    import fcsb_pkg::*;

    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [OFS_W+FRAC_W-1:0] w_ofs_q;
    logic signed [ACC_W-1:0]        w_ofs_ext;
    logic signed [ACC_W-1:0]        w_prod_ext;
    logic signed [ACC_W-1:0]        w_sum;

    // offset is Q17.16, products are Q32.32: align before adding
    assign w_ofs_q    = {i_offset, {FRAC_W{1'b0}}};
    assign w_ofs_ext  = ACC_W'(w_ofs_q);
    assign w_prod_ext = ACC_W'(r_prod);
    assign w_sum      = r_acc + w_prod_ext;
    assign o_positive = !w_sum[ACC_W-1] && (w_sum != '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.acc_init) begin
            r_acc <= w_ofs_ext + w_prod_ext;
        end else if (i_ctl.acc_add) begin
            r_acc <= w_sum;
        end
    end

endmodule

FILE: rtl/frustum_cull_sphere_box.sv
// A plane load or an unused opcode gives its result in the cycle after start is taken.
// A query steps through multiply x, y, z, then add and compare for each plane, on one
// shared 32x32 multiply-accumulate unit; it stops at the first plane that culls.
// No new transaction is taken until the last one has given its result.
// busy is high after an accepted start through the result strobe; the receiver cannot stall.
// Reset (synchronous, active low): idle, no result pending, all planes cleared to zero.
module frustum_cull_sphere_box (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fcsb_pkg::OP_W-1:0]     i_opcode,
    input  logic [fcsb_pkg::IDX_W-1:0]    i_plane_index,
    input  fcsb_pkg::t_data               i_point_x,
    input  fcsb_pkg::t_data               i_point_y,
    input  fcsb_pkg::t_data               i_point_z,
    input  fcsb_pkg::t_data               i_far_x,
    input  fcsb_pkg::t_data               i_far_y,
    input  fcsb_pkg::t_data               i_far_z,
    input  fcsb_pkg::t_data               i_scalar,
    output logic                          o_valid,
    output logic                          o_culled
);
    import fcsb_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // step within one plane: multiply x, multiply y, multiply z, final add and compare
    localparam logic [1:0] STEP_X   = 2'd0;
    localparam logic [1:0] STEP_Y   = 2'd1;
    localparam logic [1:0] STEP_Z   = 2'd2;
    localparam logic [1:0] STEP_CMP = 2'd3;

    localparam logic [IDX_W:0]     IDX_LIMIT  = (IDX_W+1)'(PLANES);
    localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(PLANES - 1);

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_step, n_step;
    logic [PLANE_W-1:0] r_plane, n_plane;
    logic               r_culled, n_culled;

    // transaction payload, held for the whole query
    logic [OP_W-1:0]    r_op;
    t_data              r_pt_x, r_pt_y, r_pt_z;
    t_data              r_far_x, r_far_y, r_far_z;
    t_data              r_scalar;

    logic               w_accept;
    logic               w_store_we;
    t_plane             w_wdata;
    t_plane             w_plane;
    t_mac_ctl           w_ctl;
    t_data              w_a, w_b;
    t_data              w_bias;
    logic signed [OFS_W-1:0] w_offset;
    logic               w_is_box;
    logic               w_positive;
    logic               w_run;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_valid  = (r_state == S_DONE);
    assign o_culled = r_culled;

    // plane loads write straight from the input ports in the accepting cycle
    assign w_wdata = '{nx: i_point_x, ny: i_point_y, nz: i_point_z, d: i_scalar};

    fcsb_plane_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_store_we),
        .i_waddr (i_plane_index[PLANE_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_plane),
        .o_rdata (w_plane)
    );

    // operand select: a box query takes the far corner on an axis whose normal is <= 0
    assign w_is_box = (r_op == OP_BOX);

    always_comb begin
        case (r_step)
            STEP_X: begin
                w_a = w_plane.nx;
                w_b = (w_is_box && (w_plane.nx <= 0)) ? r_far_x : r_pt_x;
            end
            STEP_Y: begin
                w_a = w_plane.ny;
                w_b = (w_is_box && (w_plane.ny <= 0)) ? r_far_y : r_pt_y;
            end
            default: begin
                w_a = w_plane.nz;
                w_b = (w_is_box && (w_plane.nz <= 0)) ? r_far_z : r_pt_z;
            end
        endcase
    end

    // sphere: compare distance against the radius by folding it into the offset
    assign w_bias   = (r_op == OP_SPHERE) ? r_scalar : '0;
    assign w_offset = OFS_W'(w_plane.d) - OFS_W'(w_bias);

    assign w_run          = (r_state == S_RUN);
    assign w_ctl.mul_en   = w_run && (r_step != STEP_CMP);
    assign w_ctl.acc_init = w_run && (r_step == STEP_Y);
    assign w_ctl.acc_add  = w_run && (r_step == STEP_Z);

    fcsb_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_a        (w_a),
        .i_b        (w_b),
        .i_offset   (w_offset),
        .o_positive (w_positive)
    );

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_plane    = r_plane;
        n_culled   = r_culled;
        w_store_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_culled = 1'b0;
                    n_step   = STEP_X;
                    n_plane  = '0;
                    if (i_opcode == OP_SPHERE || i_opcode == OP_BOX) begin
                        n_state = S_RUN;
                    end else begin
                        // load or unused opcode: answer at once, drop out-of-range loads
                        n_state    = S_DONE;
                        w_store_we = (i_opcode == OP_LOAD) &&
                                     ({1'b0, i_plane_index} < IDX_LIMIT);
                    end
                end
            end
            S_RUN: begin
                n_step = r_step + 2'd1;
                if (r_step == STEP_CMP) begin
                    // stop at the first plane that culls, or after the last plane
                    if (w_positive) begin
                        n_culled = 1'b1;
                    end
                    if (w_positive || (r_plane == PLANE_LAST)) begin
                        n_state = S_DONE;
                    end else begin
                        n_plane = r_plane + 1'b1;
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= STEP_X;
            r_plane  <= '0;
            r_culled <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_plane  <= n_plane;
            r_culled <= n_culled;
        end
    end

    // capture the transaction payload on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_pt_x   <= i_point_x;
            r_pt_y   <= i_point_y;
            r_pt_z   <= i_point_z;
            r_far_x  <= i_far_x;
            r_far_y  <= i_far_y;
            r_far_z  <= i_far_z;
            r_scalar <= i_scalar;
        end
    end

endmodule

FILE: rtl/fcsb_checker.sv
module fcsb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [fcsb_pkg::OP_W-1:0] i_opcode,
    input logic                      o_valid,
    input logic                      o_culled
);
    import fcsb_pkg::*;

    // an accepted transaction holds the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a result only ends a transaction in progress
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe without transaction in progress");

    // a plane load answers in the next cycle, never culled
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_LOAD)) |=> (o_valid && !o_culled))
        else $error("plane load result missing or culled");

endmodule

bind frustum_cull_sphere_box fcsb_checker u_fcsb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid),
    .o_culled (o_culled)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import fcsb_pkg::*;

    // Opcode the block leaves unused: it must answer with culled low.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam t_data ONE  = 32'sh0001_0000;
    localparam t_data HALF = 32'sh0000_8000;
    localparam t_data QMAX = 32'sh7FFF_FFFF;
    localparam t_data QMIN = 32'sh8000_0000;

    // One command as it sits on the input ports.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        t_data            px;
        t_data            py;
        t_data            pz;
        t_data            fx;
        t_data            fy;
        t_data            fz;
        t_data            sc;
    } t_cmd;

    // Wide enough for three Q32.32 products plus two scaled Q16.16 terms.
    typedef logic signed [71:0] t_dist;

    // Cull scoreboard: own copy of the plane bank, the expected culled flags in
    // transaction order, and the mismatch count.
    class t_cull_scoreboard;
        t_data       normal_x[PLANES];
        t_data       normal_y[PLANES];
        t_data       normal_z[PLANES];
        t_data       offset[PLANES];
        bit          culled_expected[$];
        int unsigned errors;
        int unsigned n_noted;
        int unsigned n_checked;

        function new();
            for (int k = 0; k < PLANES; k++) begin
                normal_x[k] = '0;
                normal_y[k] = '0;
                normal_z[k] = '0;
                offset[k]   = '0;
            end
            errors    = 0;
            n_noted   = 0;
            n_checked = 0;
        endfunction

        // True when dot(n, p) + d - bias is strictly above zero for plane k.
        function bit plane_outside(int k, t_data px, t_data py, t_data pz, t_data bias);
            t_dist acc;
            acc = t_dist'(normal_x[k]) * t_dist'(px)
                + t_dist'(normal_y[k]) * t_dist'(py)
                + t_dist'(normal_z[k]) * t_dist'(pz)
                + (t_dist'(offset[k]) <<< FRAC_W)
                - (t_dist'(bias) <<< FRAC_W);
            return acc > 0;
        endfunction

        // Apply one command to the plane bank and return its culled flag.
        function bit cull_verdict(t_cmd c);
            t_data cx;
            t_data cy;
            t_data cz;
            case (c.op)
                OP_LOAD: begin
                    if (c.idx < PLANES) begin
                        normal_x[c.idx] = c.px;
                        normal_y[c.idx] = c.py;
                        normal_z[c.idx] = c.pz;
                        offset[c.idx]   = c.sc;
                    end
                    return 1'b0;
                end
                OP_SPHERE: begin
                    for (int k = 0; k < PLANES; k++)
                        if (plane_outside(k, c.px, c.py, c.pz, c.sc))
                            return 1'b1;
                    return 1'b0;
                end
                OP_BOX: begin
                    for (int k = 0; k < PLANES; k++) begin
                        cx = (normal_x[k] <= 0) ? c.fx : c.px;
                        cy = (normal_y[k] <= 0) ? c.fy : c.py;
                        cz = (normal_z[k] <= 0) ? c.fz : c.pz;
                        if (plane_outside(k, cx, cy, cz, '0))
                            return 1'b1;
                    end
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_command(t_cmd c);
            n_noted++;
            culled_expected.push_back(cull_verdict(c));
        endfunction

        task report(string msg);
            $display("tb: %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic got);
            bit want;
            n_checked++;
            if (culled_expected.size() == 0) begin
                report($sformatf("result %0d with no transaction pending, culled=%b",
                                 n_checked, got));
                return;
            end
            want = culled_expected.pop_front();
            if (got !== want)
                report($sformatf("result %0d: culled got %b expected %b", n_checked, got, want));
        endtask

        function int pending();
            return culled_expected.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [OP_W-1:0]  i_opcode;
    logic [IDX_W-1:0] i_plane_index;
    t_data            i_point_x;
    t_data            i_point_y;
    t_data            i_point_z;
    t_data            i_far_x;
    t_data            i_far_y;
    t_data            i_far_z;
    t_data            i_scalar;
    logic             o_valid;
    logic             o_culled;

    t_cull_scoreboard sb = new();
    int unsigned      idle_pct;

    frustum_cull_sphere_box u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_plane_index (i_plane_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_far_x       (i_far_x),
        .i_far_y       (i_far_y),
        .i_far_z       (i_far_z),
        .i_scalar      (i_scalar),
        .o_valid       (o_valid),
        .o_culled      (o_culled)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Sample the ports at the rising edge, before any nonblocking update of this
    // step lands. Check the result first: a transaction taken on the same edge
    // cannot be the one that produced it.
    always @(posedge i_clk) begin
        t_cmd seen;
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_culled);
            if (start && !busy) begin
                seen.op  = i_opcode;
                seen.idx = i_plane_index;
                seen.px  = i_point_x;
                seen.py  = i_point_y;
                seen.pz  = i_point_z;
                seen.fx  = i_far_x;
                seen.fy  = i_far_y;
                seen.fz  = i_far_z;
                seen.sc  = i_scalar;
                sb.note_command(seen);
            end
        end
    end

    // Fill every field at random; callers overwrite what the opcode uses.
    function automatic t_cmd noise_cmd(logic [OP_W-1:0] op);
        t_cmd c;
        c.op  = op;
        c.idx = IDX_W'($urandom_range(7));
        c.px  = t_data'($urandom);
        c.py  = t_data'($urandom);
        c.pz  = t_data'($urandom);
        c.fx  = t_data'($urandom);
        c.fy  = t_data'($urandom);
        c.fz  = t_data'($urandom);
        c.sc  = t_data'($urandom);
        return c;
    endfunction

    function automatic t_cmd load_cmd(int idx, t_data nx, t_data ny, t_data nz, t_data d);
        t_cmd c;
        c = noise_cmd(OP_LOAD);
        c.idx = IDX_W'(idx);
        c.px  = nx;
        c.py  = ny;
        c.pz  = nz;
        c.sc  = d;
        return c;
    endfunction

    function automatic t_cmd sphere_cmd(t_data cx, t_data cy, t_data cz, t_data r);
        t_cmd c;
        c = noise_cmd(OP_SPHERE);
        c.px = cx;
        c.py = cy;
        c.pz = cz;
        c.sc = r;
        return c;
    endfunction

    function automatic t_cmd box_cmd(t_data ax, t_data ay, t_data az,
                                     t_data bx, t_data by, t_data bz);
        t_cmd c;
        c = noise_cmd(OP_BOX);
        c.px = ax;
        c.py = ay;
        c.pz = az;
        c.fx = bx;
        c.fy = by;
        c.fz = bz;
        return c;
    endfunction

    // Mostly values near the frustum, now and then full-range or extreme ones.
    function automatic t_data pick_value(int unsigned span);
        case ($urandom_range(15))
            0, 1: return t_data'($urandom);
            2: begin
                case ($urandom_range(4))
                    0: return QMAX;
                    1: return QMIN;
                    2: return t_data'(0);
                    3: return t_data'(-1);
                    default: return t_data'(1);
                endcase
            end
            default: return t_data'(int'($urandom_range(2 * span)) - int'(span));
        endcase
    endfunction

    // Drop start for a random stretch after a taken transaction.
    task automatic idle_gap();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Present one command and hold it until the block takes it. Call at a rising
    // edge; return at the edge that took it (or after the idle gap that follows).
    task automatic drive_item(input t_cmd c);
        start         <= 1'b1;
        i_opcode      <= c.op;
        i_plane_index <= c.idx;
        i_point_x     <= c.px;
        i_point_y     <= c.py;
        i_point_z     <= c.pz;
        i_far_x       <= c.fx;
        i_far_y       <= c.fy;
        i_far_z       <= c.fz;
        i_scalar      <= c.sc;
        do @(posedge i_clk); while (busy);
        idle_gap();
    endtask

    // Hold off until every outstanding transaction has produced its result.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Load a box-shaped frustum: planes 2a and 2a+1 bound axis a on the plus and
    // minus side. Tilt adds small off-axis normal components.
    task automatic load_frustum(t_data hx, t_data hy, t_data hz, bit tilt);
        t_data n[3];
        t_data h[3];
        h[0] = hx;
        h[1] = hy;
        h[2] = hz;
        for (int k = 0; k < PLANES; k++) begin
            for (int a = 0; a < 3; a++)
                n[a] = tilt ? t_data'(int'($urandom_range(8192)) - 4096) : t_data'(0);
            n[k / 2] = (k % 2) ? -ONE + n[k / 2] : ONE + n[k / 2];
            drive_item(load_cmd(k, n[0], n[1], n[2], -h[k / 2]));
        end
    endtask

    // Short directed pass over extremes and the corner cases of the culling rule.
    task automatic directed_items();
        // Empty bank: only a negative radius culls, a box never does.
        drive_item(sphere_cmd('0, '0, '0, '0));
        drive_item(sphere_cmd(QMAX, QMAX, QMAX, t_data'(-1)));
        drive_item(box_cmd(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN));
        drive_item(noise_cmd(OP_SPARE));
        // Plane index past the bank writes nothing; the query after proves it.
        drive_item(load_cmd(6, ONE, '0, '0, QMAX));
        drive_item(load_cmd(7, QMAX, QMAX, QMAX, QMAX));
        drive_item(sphere_cmd(QMAX, QMAX, QMAX, '0));
        // Extreme planes and extreme objects.
        drive_item(load_cmd(0, QMAX, QMIN, '0, QMAX));
        drive_item(load_cmd(5, QMIN, QMIN, QMIN, QMIN));
        drive_item(load_cmd(2, t_data'(-1), t_data'(1), QMAX, t_data'(-1)));
        drive_item(sphere_cmd(QMIN, QMAX, QMIN, QMAX));
        drive_item(sphere_cmd(QMAX, QMAX, QMAX, QMIN));
        drive_item(box_cmd(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX));
        drive_item(box_cmd(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN));
        // Unit cube frustum: probe the strict compare right at the boundary.
        load_frustum(ONE, ONE, ONE, 1'b0);
        drive_item(sphere_cmd(ONE + HALF, '0, '0, HALF));
        drive_item(sphere_cmd(ONE + HALF + 1, '0, '0, HALF));
        drive_item(box_cmd(ONE, -ONE, -ONE, ONE + ONE, ONE, ONE));
        drive_item(box_cmd(ONE + 1, -ONE, -ONE, ONE + ONE, ONE, ONE));
        drive_item(box_cmd(-HALF, -HALF, -HALF, HALF, HALF, HALF));
    endtask

    // Random traffic: frustum reloads, stray loads, spare opcodes, and mostly
    // sphere and box queries around the loaded planes.
    task automatic run_random(int unsigned count);
        int unsigned sent;
        int unsigned roll;
        int unsigned ext;
        t_data       lo[3];
        t_data       hi[3];
        t_cmd        c;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                load_frustum(t_data'($urandom_range(1, 1 << 22)),
                             t_data'($urandom_range(1, 1 << 22)),
                             t_data'($urandom_range(1, 1 << 22)),
                             1'($urandom_range(1)));
                sent += PLANES;
            end else begin
                if (roll < 16) begin
                    c = noise_cmd(OP_LOAD);
                    c.px = pick_value(1 << 17);
                    c.py = pick_value(1 << 17);
                    c.pz = pick_value(1 << 17);
                    c.sc = pick_value(1 << 22);
                end else if (roll < 19) begin
                    c = noise_cmd(OP_SPARE);
                end else if (roll < 60) begin
                    c = sphere_cmd(pick_value(1 << 23), pick_value(1 << 23),
                                   pick_value(1 << 23),
                                   ($urandom_range(3) == 0) ? pick_value(1 << 20)
                                                            : t_data'($urandom_range(1 << 20)));
                end else begin
                    // Build min and max corners; now and then leave them swapped.
                    for (int a = 0; a < 3; a++) begin
                        ext   = $urandom_range(1 << 21);
                        lo[a] = pick_value(1 << 23);
                        hi[a] = ($urandom_range(9) == 0) ? t_data'(int'(lo[a]) - int'(ext))
                                                         : t_data'(int'(lo[a]) + int'(ext));
                    end
                    c = box_cmd(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
                end
                drive_item(c);
                sent++;
            end
        end
    endtask

    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_LOAD;
        i_plane_index = '0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_point_z     = '0;
        i_far_x       = '0;
        i_far_y       = '0;
        i_far_z       = '0;
        i_scalar      = '0;
        idle_pct      = 34;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        wait_drained();

        // Sender idles about a third of the time.
        run_random(430);
        // Pause the sender until the block has answered everything.
        wait_drained();

        // Sender idles most of the time.
        idle_pct = 79;
        run_random(430);
        wait_drained();

        // Back-to-back transactions, no idling at all.
        idle_pct = 0;
        run_random(440);

        // Let the last query finish, then keep watching for strays.
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb: timeout with %0d transaction(s) outstanding", sb.pending());
        $display("tb: done, errors");
        $finish;
    end

endmodule
